### hw/rtl/hpti_pkg.sv
// Shared types and constants of the hashed pair table insert unit.
`timescale 1ns / 1ps

package hpti_pkg;

    // Field widths fixed by the request and response formats.
    localparam int TYPE_W  = 4;
    localparam int CFG_W   = 4;
    localparam int SLOT_W  = 8;
    localparam int PROBE_W = 9;

    // Reset value of the table size register (log2 of the active size).
    localparam logic [CFG_W-1:0] CFG_SIZE_LOG2_RESET = 4'd7;

    // FNV-1a constants; the key is two 32-bit words hashed one byte per step.
    localparam logic [31:0] HASH_BASIS      = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME      = 32'd16777619;
    localparam int          HASH_WORD_BYTES = 4;
    localparam int          HASH_STEPS      = 2 * HASH_WORD_BYTES;
    localparam int          HASH_CNT_W      = $clog2(HASH_STEPS);

    // Response status codes.
    localparam logic STATUS_PLACED = 1'b0;
    localparam logic STATUS_FULL   = 1'b1;

    // One insert request.
    typedef struct packed {
        logic [TYPE_W-1:0] first_reactant;
        logic [TYPE_W-1:0] second_reactant;
        logic [TYPE_W-1:0] first_product;
        logic [TYPE_W-1:0] second_product;
    } t_req;

    // One insert response.
    typedef struct packed {
        logic               status;
        logic [SLOT_W-1:0]  slot;
        logic [PROBE_W-1:0] probes_used;
        logic [PROBE_W-1:0] longest_chain;
    } t_rsp;

    // One table entry; the reactants sit in the low byte.
    typedef struct packed {
        logic [TYPE_W-1:0] second_product;
        logic [TYPE_W-1:0] first_product;
        logic [TYPE_W-1:0] second_reactant;
        logic [TYPE_W-1:0] first_reactant;
    } t_entry;

    // Table port controls driven by the sequencer.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_tbl_ctl;

endpackage

### hw/rtl/hashed_pair_table_insert_unit.sv
// Top level of the hashed pair table insert unit: sequencer, size register, result.
//
// Each request inserts one entry (two reactant types, two product types) into an
// open-addressed table. The key is hashed with FNV-1a and folded, then a
// triangular probe walk looks for the first slot whose reactants are both zero.
// Requests arrive on i_req_valid / o_req_ready; responses leave on
// o_rsp_valid / i_rsp_ready and carry status, slot, probe count and the longest
// probe run since reset. i_cfg_we writes the log2 table size (reset value 7).
// One request is in flight at a time. After acceptance the key is hashed on the
// shared hash multiplier; each probe is then one table read and one compare,
// since the table has a single port with registered read data. The next request
// is taken the cycle after the response is accepted.
// After reset a clearing pass writes every table entry to zero, one per cycle;
// no request is taken meanwhile. A stalled response holds in its output register.
`timescale 1ns / 1ps

module hashed_pair_table_insert_unit
    import hpti_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  t_req             i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output t_rsp             o_rsp,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int FLOOR_LOG2 = $clog2(TABLE_DEPTH + 1) - 1;
    localparam int ADDR_W     = (FLOOR_LOG2 > 0) ? FLOOR_LOG2 : 1;
    localparam int MAX_SIZE   = 1 << FLOOR_LOG2;
    localparam int STEP_W     = ADDR_W + 1;
    localparam int CMP_W      = (STEP_W > PROBE_W) ? STEP_W : PROBE_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_ADDR  = 6'b001000,
        S_CHECK = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [CFG_W-1:0]    r_size_log2;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [ADDR_W-1:0]   r_index;
    logic [ADDR_W-1:0]   n_index;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   n_step;
    logic [PROBE_W-1:0]  r_longest;
    logic [PROBE_W-1:0]  n_longest;
    t_entry              r_entry;
    t_rsp                r_rsp;
    t_rsp                n_rsp;

    logic                w_accept;
    logic                w_hash_done;
    logic [31:0]         w_hash;
    logic [STEP_W-1:0]   w_size;
    logic [ADDR_W-1:0]   w_mask;
    logic [ADDR_W-1:0]   w_probe_idx;
    logic                w_empty;
    logic                w_finish;
    t_tbl_ctl            w_tbl_ctl;
    logic [ADDR_W-1:0]   w_tbl_addr;
    t_entry              w_tbl_wdata;
    t_entry              w_tbl_rdata;

    assign w_accept    = i_req_valid && o_req_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_DONE);
    assign o_rsp       = r_rsp;

    // Size register; the host must write it only while no request is in flight (not enforced here).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= CFG_SIZE_LOG2_RESET;
        end else if (i_cfg_we) begin
            r_size_log2 <= i_cfg_wdata;
        end
    end

    // Active size saturates at the largest power of two the table holds.
    always_comb begin
        if (int'(r_size_log2) > FLOOR_LOG2) begin
            w_size = STEP_W'(MAX_SIZE);
        end else begin
            w_size = STEP_W'(1) << r_size_log2;
        end
        w_mask      = ADDR_W'(w_size - 1'b1);
        w_probe_idx = (r_index + ADDR_W'(r_step)) & w_mask;
        w_empty     = (w_tbl_rdata.first_reactant == '0) &&
                      (w_tbl_rdata.second_reactant == '0);
    end

    // Key hash unit.
    hpti_hash u_hash (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (w_accept),
        .i_first_reactant  (i_req.first_reactant),
        .i_second_reactant (i_req.second_reactant),
        .o_done            (w_hash_done),
        .o_hash            (w_hash)
    );

    // Table port: clear sweep, probe read, or entry write.
    always_comb begin
        w_tbl_ctl   = '0;
        w_tbl_addr  = r_index;
        w_tbl_wdata = r_entry;
        case (r_state)
            S_CLEAR: begin
                w_tbl_ctl.wr_en = 1'b1;
                w_tbl_addr      = r_clr_addr;
                w_tbl_wdata     = '0;
            end
            S_ADDR: begin
                w_tbl_ctl.rd_en = 1'b1;
                w_tbl_addr      = w_probe_idx;
            end
            S_CHECK: begin
                w_tbl_ctl.wr_en = w_empty;
            end
            default: begin
                w_tbl_ctl = '0;
            end
        endcase
    end

    hpti_table #(
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_ctl   (w_tbl_ctl),
        .i_addr  (w_tbl_addr),
        .i_wdata (w_tbl_wdata),
        .o_rdata (w_tbl_rdata)
    );

    // Sequencer and probe walk.
    always_comb begin
        n_state   = r_state;
        n_index   = r_index;
        n_step    = r_step;
        n_longest = r_longest;
        n_rsp     = r_rsp;
        w_finish  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_W'((1 << ADDR_W) - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (w_hash_done) begin
                    n_index = w_hash[ADDR_W-1:0];
                    n_step  = '0;
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                n_index = w_probe_idx;
                n_step  = r_step + 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_empty) begin
                    w_finish     = 1'b1;
                    n_rsp.status = STATUS_PLACED;
                    n_rsp.slot   = SLOT_W'(r_index);
                end else if (r_step == w_size) begin
                    w_finish     = 1'b1;
                    n_rsp.status = STATUS_FULL;
                    n_rsp.slot   = '0;
                end else begin
                    n_state = S_ADDR;
                end
                if (w_finish) begin
                    if (CMP_W'(r_step) > CMP_W'(r_longest)) begin
                        n_longest = PROBE_W'(r_step);
                    end
                    n_rsp.probes_used   = PROBE_W'(r_step);
                    n_rsp.longest_chain = n_longest;
                    n_state             = S_DONE;
                end
            end
            S_DONE: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_longest  <= '0;
        end else begin
            r_state   <= n_state;
            r_longest <= n_longest;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_index <= n_index;
        r_step  <= n_step;
        r_rsp   <= n_rsp;
        if (w_accept) begin
            r_entry.first_reactant  <= i_req.first_reactant;
            r_entry.second_reactant <= i_req.second_reactant;
            r_entry.first_product   <= i_req.first_product;
            r_entry.second_product  <= i_req.second_product;
        end
    end

`ifndef SYNTHESIS
    // Requests are never taken while a response is pending.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_req_ready && o_rsp_valid))
        else $error("request ready while a response is pending");

    // A response never appears right after a request is accepted.
    a_no_early_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_rsp_valid)
        else $error("response valid in the cycle after acceptance");

    // A full table reports slot zero.
    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_rsp.status == STATUS_FULL)) |-> (o_rsp.slot == '0))
        else $error("full status with a nonzero slot");

    // The longest chain never shrinks between responses.
    a_longest_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> (r_longest >= $past(r_longest)))
        else $error("longest chain decreased");
`endif

endmodule

### hw/rtl/hpti_hash.sv
// Iterative FNV-1a key hash with one shared 32-bit multiplier.
`timescale 1ns / 1ps

module hpti_hash
    import hpti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TYPE_W-1:0] i_first_reactant,
    input  logic [TYPE_W-1:0] i_second_reactant,
    output logic              o_done,
    output logic [31:0]       o_hash
);

    logic [31:0]           r_h;
    logic [31:0]           n_h;
    logic [HASH_CNT_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [TYPE_W-1:0]     r_key0;
    logic [TYPE_W-1:0]     r_key1;
    logic [7:0]            w_byte;
    logic [31:0]           w_mixed;

    // Only the low byte of each key word is nonzero.
    always_comb begin
        if (r_cnt == '0) begin
            w_byte = 8'(r_key0);
        end else if (r_cnt == HASH_CNT_W'(HASH_WORD_BYTES)) begin
            w_byte = 8'(r_key1);
        end else begin
            w_byte = 8'd0;
        end
        w_mixed = r_h ^ {24'd0, w_byte};
        n_h     = w_mixed * HASH_PRIME;
    end

    // One multiply per cycle over the eight key bytes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == HASH_CNT_W'(HASH_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == HASH_CNT_W'(HASH_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Hash datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_h    <= HASH_BASIS;
            r_key0 <= i_first_reactant;
            r_key1 <= i_second_reactant;
        end else if (r_busy) begin
            r_h <= n_h;
        end
    end

    // Fold the upper half into the lower half.
    assign o_done = r_done;
    assign o_hash = r_h ^ {16'd0, r_h[31:16]};

endmodule

### hw/rtl/hpti_table.sv
// Entry table memory with one address port and registered read data.
`timescale 1ns / 1ps

module hpti_table
    import hpti_pkg::*;
#(
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  t_tbl_ctl          i_ctl,
    input  logic [ADDR_W-1:0] i_addr,
    input  t_entry            i_wdata,
    output t_entry            o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write and registered read share the address.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
